FILE: sv/adcsup_pkg.sv
`default_nettype none
package adcsup_pkg;

  localparam int RAW_W = 12;
  localparam int CNT_W = 32;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int NUM_CNT = 5;

  localparam logic [CFG_W-1:0] PERIOD_RST = 16'd5;
  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd50;

  localparam logic [2:0] CNT_INIT = 3'd0;
  localparam logic [2:0] CNT_START = 3'd1;
  localparam logic [2:0] CNT_TIMEOUT = 3'd2;
  localparam logic [2:0] CNT_LATE = 3'd3;
  localparam logic [2:0] CNT_IRQ = 3'd4;

  typedef enum logic [2:0] {
    ACT_INIT    = 3'd0,
    ACT_SERVICE = 3'd1,
    ACT_IRQ     = 3'd2,
    ACT_ERROR   = 3'd3,
    ACT_READ    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [TIME_W-1:0] now_ms;
    logic              init_ok;
    logic              start_ok;
    logic              overrun_flag;
    logic              conversion_done;
    logic [15:0]       conversion_data;
  } evt_t;

  typedef struct packed {
    logic [1:0]        adc_command;
    logic [RAW_W-1:0]  published_raw;
    logic [TIME_W-1:0] published_time;
    logic [CNT_W-1:0]  published_seq;
    logic              published_valid;
    logic              block_ready;
    logic              pending_now;
    logic [CNT_W-1:0]  init_error_count;
    logic [CNT_W-1:0]  start_error_count;
    logic [CNT_W-1:0]  timeout_count;
    logic [CNT_W-1:0]  late_irq_count;
    logic [CNT_W-1:0]  irq_error_count;
  } res_t;

  typedef struct packed {
    logic [CFG_W-1:0] request_period_ms;
    logic [CFG_W-1:0] sample_timeout_ms;
  } cfg_t;

endpackage
`default_nettype wire

FILE: sv/adcsup_cfg.sv
`default_nettype none
module adcsup_cfg
  import adcsup_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready,
  output      cfg_t        cfg
);

  logic [CFG_W-1:0] period_r;
  logic [CFG_W-1:0] timeout_r;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (wr_en) begin
      if (cfg_paddr[2]) begin
        timeout_r <= cfg_pwdata[CFG_W-1:0];
      end else begin
        period_r <= cfg_pwdata[CFG_W-1:0];
      end
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? {{(32-CFG_W){1'b0}}, timeout_r}
                                   : {{(32-CFG_W){1'b0}}, period_r};

  assign cfg.request_period_ms = period_r;
  assign cfg.sample_timeout_ms = timeout_r;

endmodule
`default_nettype wire

FILE: sv/adcsup_core.sv
`default_nettype none
module adcsup_core
  import adcsup_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire evt_t evt,
  input  wire cfg_t cfg,
  output      res_t res_nxt
);

  logic              ready_r, ready_nxt;
  logic              pending_r, pending_nxt;
  logic              seen_r, seen_nxt;
  logic              ok_r, ok_nxt;
  logic [TIME_W-1:0] req_time_r, req_time_nxt;
  logic [RAW_W-1:0]  raw_r, raw_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;
  logic [CNT_W-1:0]  seq_r, seq_nxt;
  logic [CNT_W-1:0]  cnt_r [NUM_CNT];
  logic [CNT_W-1:0]  cnt_nxt [NUM_CNT];

  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] sample_age;
  logic              age_tmo;
  logic              age_per;
  logic              fresh;
  logic              fail;
  logic              valid;
  cmd_t              cmd;

  assign age = evt.now_ms - req_time_r;
  assign sample_age = evt.now_ms - stamp_r;
  assign age_tmo = age >= {{(TIME_W-CFG_W){1'b0}}, cfg.sample_timeout_ms};
  assign age_per = age >= {{(TIME_W-CFG_W){1'b0}}, cfg.request_period_ms};
  assign fresh = sample_age[TIME_W-1] ||
                 (sample_age < {{(TIME_W-CFG_W){1'b0}}, cfg.sample_timeout_ms});

  always_comb begin
    ready_nxt = ready_r;
    pending_nxt = pending_r;
    seen_nxt = seen_r;
    ok_nxt = ok_r;
    req_time_nxt = req_time_r;
    raw_nxt = raw_r;
    stamp_nxt = stamp_r;
    seq_nxt = seq_r;
    cnt_nxt = cnt_r;
    cmd = CMD_NONE;
    fail = 1'b0;
    case (evt.action)
      ACT_INIT: begin
        if (!pending_r) begin
          ready_nxt = evt.init_ok;
          ok_nxt = 1'b0;
          seen_nxt = 1'b0;
          if (!evt.init_ok) begin
            cnt_nxt[CNT_INIT] = cnt_r[CNT_INIT] + 32'd1;
            fail = 1'b1;
          end
        end
      end
      ACT_SERVICE: begin
        if (ready_r) begin
          if (pending_r) begin
            if (age_tmo) begin
              cnt_nxt[CNT_TIMEOUT] = cnt_r[CNT_TIMEOUT] + 32'd1;
              fail = 1'b1;
              cmd = CMD_STOP;
            end
          end else if (!seen_r || age_per) begin
            req_time_nxt = evt.now_ms;
            seen_nxt = 1'b1;
            pending_nxt = 1'b1;
            if (evt.start_ok) begin
              cmd = CMD_START;
            end else begin
              cnt_nxt[CNT_START] = cnt_r[CNT_START] + 32'd1;
              fail = 1'b1;
              cmd = CMD_STOP;
            end
          end
        end
      end
      ACT_IRQ: begin
        if (!ready_r || !pending_r) begin
          cnt_nxt[CNT_LATE] = cnt_r[CNT_LATE] + 32'd1;
        end else if (evt.overrun_flag) begin
          cnt_nxt[CNT_IRQ] = cnt_r[CNT_IRQ] + 32'd1;
          fail = 1'b1;
        end else if (age_tmo) begin
          cnt_nxt[CNT_TIMEOUT] = cnt_r[CNT_TIMEOUT] + 32'd1;
          fail = 1'b1;
        end else if (evt.conversion_done) begin
          raw_nxt = evt.conversion_data[RAW_W-1:0];
          stamp_nxt = evt.now_ms;
          seq_nxt = seq_r + 32'd1;
          ok_nxt = 1'b1;
          pending_nxt = 1'b0;
        end
      end
      ACT_ERROR: begin
        cnt_nxt[CNT_IRQ] = cnt_r[CNT_IRQ] + 32'd1;
        fail = 1'b1;
      end
      default: begin
      end
    endcase
    if (fail) begin
      ok_nxt = 1'b0;
      ready_nxt = 1'b0;
      pending_nxt = 1'b0;
    end
    valid = ok_nxt;
    if ((evt.action == ACT_READ) && (!ready_nxt || !fresh)) begin
      valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      pending_r <= 1'b0;
      seen_r <= 1'b0;
      ok_r <= 1'b0;
      req_time_r <= '0;
      raw_r <= '0;
      stamp_r <= '0;
      seq_r <= '0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (step) begin
      ready_r <= ready_nxt;
      pending_r <= pending_nxt;
      seen_r <= seen_nxt;
      ok_r <= ok_nxt;
      req_time_r <= req_time_nxt;
      raw_r <= raw_nxt;
      stamp_r <= stamp_nxt;
      seq_r <= seq_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign res_nxt.adc_command = cmd;
  assign res_nxt.published_raw = raw_nxt;
  assign res_nxt.published_time = stamp_nxt;
  assign res_nxt.published_seq = seq_nxt;
  assign res_nxt.published_valid = valid;
  assign res_nxt.block_ready = ready_nxt;
  assign res_nxt.pending_now = pending_nxt;
  assign res_nxt.init_error_count = cnt_nxt[CNT_INIT];
  assign res_nxt.start_error_count = cnt_nxt[CNT_START];
  assign res_nxt.timeout_count = cnt_nxt[CNT_TIMEOUT];
  assign res_nxt.late_irq_count = cnt_nxt[CNT_LATE];
  assign res_nxt.irq_error_count = cnt_nxt[CNT_IRQ];

endmodule
`default_nettype wire

FILE: sv/adc_sample_acquisition_supervisor_unit.sv
// Channel  Dir  Handshake                   Payload
// in_      in   in_tvalid / in_tready       in_tuser (action), in_tdata (event fields)
// out_     out  out_tvalid / out_tready     out_tdata (command, sample, flags, counters)
// cfg_     in   APB psel/penable, pready=1  request period, sample timeout
//
// One event per clock sustained while out_tready is high; every event gives exactly one result.
// An event passes the input register, then the state update into the result register.
// A stalled result holds in the output register while one more event waits in the
// input register. Synchronous active-low reset clears all flags, the sample and counters.
`default_nettype none
module adc_sample_acquisition_supervisor_unit
  import adcsup_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // [2:0] action
  input  wire logic [2:0]   in_tuser,
  // [31:0] now_ms, [32] init_ok, [33] start_ok, [34] overrun_flag,
  // [35] conversion_done, [51:36] conversion_data, [55:52] zero
  input  wire logic [55:0]  in_tdata,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // [1:0] adc_command, [13:2] published_raw, [45:14] published_time,
  // [77:46] published_seq, [78] published_valid, [79] block_ready,
  // [80] pending_now, [112:81] init_error_count, [144:113] start_error_count,
  // [176:145] timeout_count, [208:177] late_irq_count,
  // [240:209] irq_error_count, [247:241] zero
  output      logic [247:0] out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output      logic [31:0]  cfg_prdata,
  output      logic         cfg_pready
);

  cfg_t cfg;
  evt_t evt_r;
  logic in_valid_r;
  res_t res_nxt;
  res_t res_r;
  logic out_valid_r;
  logic step;

  adcsup_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign step = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      evt_r.action <= in_tuser;
      evt_r.now_ms <= in_tdata[31:0];
      evt_r.init_ok <= in_tdata[32];
      evt_r.start_ok <= in_tdata[33];
      evt_r.overrun_flag <= in_tdata[34];
      evt_r.conversion_done <= in_tdata[35];
      evt_r.conversion_data <= in_tdata[51:36];
    end
  end

  adcsup_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .evt     (evt_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {
    7'd0,
    res_r.irq_error_count,
    res_r.late_irq_count,
    res_r.timeout_count,
    res_r.start_error_count,
    res_r.init_error_count,
    res_r.pending_now,
    res_r.block_ready,
    res_r.published_valid,
    res_r.published_seq,
    res_r.published_time,
    res_r.published_raw,
    res_r.adc_command
  };

endmodule
`default_nettype wire

FILE: verif/adcsup_result_checker.sv
`timescale 1ns / 100ps
module adcsup_result_checker
  import adcsup_pkg::*;
#(
  parameter logic [2:0] PERIOD_ADDR  = 3'd0,
  parameter logic [2:0] TIMEOUT_ADDR = 3'd4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [2:0]   in_tuser,
  input  logic [55:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [247:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic         cfg_pready,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic [31:0]  cfg_prdata,
  output int           status_owed,
  output int           mismatches
);

  logic [CFG_W-1:0]  period_ms;
  logic [CFG_W-1:0]  timeout_ms;

  logic              is_ready;
  logic              conv_pending;
  logic              requested;
  logic [TIME_W-1:0] req_stamp;
  logic [RAW_W-1:0]  raw_q;
  logic [TIME_W-1:0] stamp_q;
  logic [CNT_W-1:0]  seq_q;
  logic              sample_valid;
  logic [CNT_W-1:0]  err_cnt [NUM_CNT];

  res_t awaited_status [$];

  function automatic void close_down();
    sample_valid = 1'b0;
    is_ready     = 1'b0;
    conv_pending = 1'b0;
  endfunction

  function automatic res_t supervise_event(logic [2:0] act, logic [TIME_W-1:0] now,
                                           logic init_ok, logic start_ok, logic overrun,
                                           logic done, logic [15:0] data);
    res_t              r;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] since;
    logic              fresh;
    r = '0;
    r.adc_command = CMD_NONE;
    age = now - req_stamp;
    case (act)
      ACT_INIT: begin
        if (!conv_pending) begin
          sample_valid = 1'b0;
          requested    = 1'b0;
          is_ready     = init_ok;
          if (!init_ok) begin
            err_cnt[CNT_INIT] += 1;
            close_down();
          end
        end
      end
      ACT_SERVICE: begin
        if (is_ready) begin
          if (conv_pending) begin
            if (age >= TIME_W'(timeout_ms)) begin
              err_cnt[CNT_TIMEOUT] += 1;
              close_down();
              r.adc_command = CMD_STOP;
            end
          end else if (!requested || age >= TIME_W'(period_ms)) begin
            req_stamp    = now;
            requested    = 1'b1;
            conv_pending = 1'b1;
            if (start_ok) begin
              r.adc_command = CMD_START;
            end else begin
              err_cnt[CNT_START] += 1;
              close_down();
              r.adc_command = CMD_STOP;
            end
          end
        end
      end
      ACT_IRQ: begin
        if (!is_ready || !conv_pending) begin
          err_cnt[CNT_LATE] += 1;
        end else if (overrun) begin
          err_cnt[CNT_IRQ] += 1;
          close_down();
        end else if (age >= TIME_W'(timeout_ms)) begin
          err_cnt[CNT_TIMEOUT] += 1;
          close_down();
        end else if (done) begin
          raw_q        = data[RAW_W-1:0];
          stamp_q      = now;
          seq_q        = seq_q + 1;
          sample_valid = 1'b1;
          conv_pending = 1'b0;
        end
      end
      ACT_ERROR: begin
        err_cnt[CNT_IRQ] += 1;
        close_down();
      end
      default: ;
    endcase

    r.published_valid = sample_valid;
    if (act == ACT_READ) begin
      since = now - stamp_q;
      fresh = since[TIME_W-1] || (since < TIME_W'(timeout_ms));
      if (!is_ready || !fresh) r.published_valid = 1'b0;
    end
    r.published_raw     = raw_q;
    r.published_time    = stamp_q;
    r.published_seq     = seq_q;
    r.block_ready       = is_ready;
    r.pending_now       = conv_pending;
    r.init_error_count  = err_cnt[CNT_INIT];
    r.start_error_count = err_cnt[CNT_START];
    r.timeout_count     = err_cnt[CNT_TIMEOUT];
    r.late_irq_count    = err_cnt[CNT_LATE];
    r.irq_error_count   = err_cnt[CNT_IRQ];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_status(res_t want, logic [247:0] d);
    check_field("adc_command",       32'(want.adc_command),     32'(d[1:0]));
    check_field("published_raw",     32'(want.published_raw),   32'(d[13:2]));
    check_field("published_time",    want.published_time,       d[45:14]);
    check_field("published_seq",     want.published_seq,        d[77:46]);
    check_field("published_valid",   32'(want.published_valid), 32'(d[78]));
    check_field("block_ready",       32'(want.block_ready),     32'(d[79]));
    check_field("pending_now",       32'(want.pending_now),     32'(d[80]));
    check_field("init_error_count",  want.init_error_count,     d[112:81]);
    check_field("start_error_count", want.start_error_count,    d[144:113]);
    check_field("timeout_count",     want.timeout_count,        d[176:145]);
    check_field("late_irq_count",    want.late_irq_count,       d[208:177]);
    check_field("irq_error_count",   want.irq_error_count,      d[240:209]);
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      period_ms    = PERIOD_RST;
      timeout_ms   = TIMEOUT_RST;
      is_ready     = 1'b0;
      conv_pending = 1'b0;
      requested    = 1'b0;
      req_stamp    = '0;
      raw_q        = '0;
      stamp_q      = '0;
      seq_q        = '0;
      sample_valid = 1'b0;
      for (int i = 0; i < NUM_CNT; i++) err_cnt[i] = '0;
      awaited_status.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == PERIOD_ADDR) period_ms = cfg_pwdata[CFG_W-1:0];
          else if (cfg_paddr == TIMEOUT_ADDR) timeout_ms = cfg_pwdata[CFG_W-1:0];
        end else if (cfg_paddr == PERIOD_ADDR) begin
          check_field("request_period_ms readback", {16'b0, period_ms}, cfg_prdata);
        end else if (cfg_paddr == TIMEOUT_ADDR) begin
          check_field("sample_timeout_ms readback", {16'b0, timeout_ms}, cfg_prdata);
        end
      end
      if (out_tvalid && out_tready) begin
        if (awaited_status.size() == 0) begin
          $display("%0t unexpected status transfer: expected none, actual %0h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          compare_status(awaited_status.pop_front(), out_tdata);
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_status.push_back(supervise_event(in_tuser, in_tdata[31:0], in_tdata[32],
                                                 in_tdata[33], in_tdata[34], in_tdata[35],
                                                 in_tdata[51:36]));
      end
    end
    status_owed = awaited_status.size();
  end

endmodule

FILE: verif/tb_adc_sample_acquisition_supervisor_unit.sv
`timescale 1ns / 100ps
module tb_adc_sample_acquisition_supervisor_unit;
  import adcsup_pkg::*;

  localparam logic [2:0] PERIOD_ADDR  = 3'd0;
  localparam logic [2:0] TIMEOUT_ADDR = 3'd4;
  localparam int         CYCLE_LIMIT  = 200000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [2:0]   in_tuser = '0;
  logic [55:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [247:0] out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int           status_owed;
  int           mismatches;
  int           cycles = 0;
  logic         gaps_on = 1'b1;
  logic [31:0]  tick_ms = '0;
  logic [15:0]  period_ms = PERIOD_RST;
  logic [15:0]  timeout_ms = TIMEOUT_RST;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  adc_sample_acquisition_supervisor_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  adcsup_result_checker #(
    .PERIOD_ADDR  (PERIOD_ADDR),
    .TIMEOUT_ADDR (TIMEOUT_ADDR)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .status_owed (status_owed),
    .mismatches  (mismatches)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(gaps_on && $urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_adc_sample_acquisition_supervisor_unit NOT OK");
      $finish;
    end
  end

  // flg: {conversion_done, overrun_flag, start_ok, init_ok}
  task automatic post_event(logic [2:0] act, logic [31:0] now, logic [3:0] flg,
                            logic [15:0] data);
    while (gaps_on && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'b0, data, flg, now};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic await_all_status();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (status_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_register(logic [2:0] addr, logic [15:0] value);
    logic [15:0] junk;
    junk = 16'($urandom_range(16'hFFFF));
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {junk, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // mostly below the limit, sometimes right on it or past it
  function automatic logic [31:0] age_step(logic [15:0] lim);
    int unsigned r;
    r = $urandom_range(99);
    if (lim == 0) return $urandom_range(3);
    if (r < 70) return $urandom_range(lim - 1);
    if (r < 85) return 32'(lim);
    return lim + $urandom_range(lim);
  endfunction

  task automatic random_events(int n_items);
    int          k;
    int          rounds;
    logic [3:0]  flg;
    logic [2:0]  act;
    logic [31:0] t;
    k = 0;
    while (k < n_items) begin
      if ($urandom_range(99) < 85) begin
        tick_ms += $urandom_range(3);
        flg = 4'($urandom_range(15));
        flg[0] = ($urandom_range(99) < 95);
        post_event(ACT_INIT, tick_ms, flg, 16'($urandom_range(16'hFFFF)));
        k++;
        rounds = $urandom_range(8, 1);
        repeat (rounds) begin
          tick_ms += age_step(period_ms);
          flg = 4'($urandom_range(15));
          flg[1] = ($urandom_range(99) < 95);
          post_event(ACT_SERVICE, tick_ms, flg, 16'($urandom_range(16'hFFFF)));
          tick_ms += age_step(timeout_ms);
          flg = 4'($urandom_range(15));
          flg[2] = ($urandom_range(99) < 4);
          flg[3] = ($urandom_range(99) < 90);
          post_event(ACT_IRQ, tick_ms, flg, 16'($urandom_range(16'hFFFF)));
          k += 2;
          if ($urandom_range(1)) begin
            t = ($urandom_range(9) == 0) ? tick_ms - $urandom_range(200)
                                          : tick_ms + age_step(timeout_ms);
            post_event(ACT_READ, t, 4'($urandom_range(15)),
                       16'($urandom_range(16'hFFFF)));
            k++;
          end
        end
      end else begin
        act = 3'($urandom_range(7));
        t = $urandom_range(1) ? $urandom : tick_ms + $urandom_range(100);
        post_event(act, t, 4'($urandom_range(15)), 16'($urandom_range(16'hFFFF)));
        if (act <= ACT_READ) k++;
      end
    end
  endtask

  task automatic run_phase(logic [15:0] period, logic [15:0] timeout, logic gaps, int n_items);
    await_all_status();
    gaps_on <= gaps;
    program_register(PERIOD_ADDR, period);
    program_register(TIMEOUT_ADDR, timeout);
    period_ms  = period;
    timeout_ms = timeout;
    random_events(n_items);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    post_event(ACT_READ,    32'd0,   4'b0000, 16'h0000);
    post_event(ACT_SERVICE, 32'd1,   4'b0010, 16'h0000);
    post_event(ACT_IRQ,     32'd2,   4'b1000, 16'h0123);
    post_event(ACT_INIT,    32'd3,   4'b0000, 16'h0000);
    post_event(ACT_INIT,    32'd4,   4'b0001, 16'h0000);
    post_event(ACT_SERVICE, 32'd100, 4'b0010, 16'h0000);
    post_event(ACT_INIT,    32'd101, 4'b0000, 16'h0000);
    post_event(ACT_IRQ,     32'd102, 4'b0000, 16'h0ABC);
    post_event(ACT_IRQ,     32'd103, 4'b1000, 16'hFFFF);
    post_event(ACT_READ,    32'd103 + 32'h8000_0000, 4'b0000, 16'h0000);
    post_event(ACT_READ,    32'd103 + 32'h7FFF_FFFF, 4'b0000, 16'h0000);
    post_event(ACT_SERVICE, 32'd104, 4'b0010, 16'h0000);
    post_event(ACT_SERVICE, 32'd105, 4'b0000, 16'h0000);
    post_event(ACT_INIT,    32'd106, 4'b0001, 16'h0000);
    post_event(ACT_SERVICE, 32'd107, 4'b0010, 16'h0000);
    post_event(ACT_IRQ,     32'd108, 4'b1100, 16'h0555);
    post_event(ACT_INIT,    32'd109, 4'b0001, 16'h0000);
    post_event(ACT_SERVICE, 32'd110, 4'b0010, 16'h0000);
    post_event(ACT_SERVICE, 32'd160, 4'b0010, 16'h0000);
    post_event(ACT_INIT,    32'd161, 4'b0001, 16'h0000);
    post_event(ACT_SERVICE, 32'd170, 4'b0010, 16'h0000);
    post_event(ACT_IRQ,     32'd220, 4'b1000, 16'h0777);
    post_event(ACT_INIT,    32'd221, 4'b0001, 16'h0000);
    post_event(ACT_SERVICE, 32'd230, 4'b0010, 16'h0000);
    post_event(ACT_IRQ,     32'd231, 4'b1000, 16'h0000);
    post_event(ACT_READ,    32'd280, 4'b0000, 16'h0000);
    post_event(ACT_READ,    32'd281, 4'b0000, 16'h0000);
    post_event(ACT_ERROR,   32'd282, 4'b0000, 16'h0000);
    for (int a = ACT_READ + 1; a < 8; a++) post_event(3'(a), 32'd283, 4'b1111, 16'hFFFF);
    tick_ms = 32'd300;

    run_phase(16'd1,     16'd65535, 1'b0, 170);
    run_phase(16'd65535, 16'd1,     1'b1, 140);
    run_phase(16'd0,     16'd0,     1'b1, 120);
    run_phase(16'd7,     16'd20,    1'b1, 125);
    await_all_status();
    random_events(125);
    run_phase(16'd2,     16'd3,     1'b1, 120);
    tick_ms = 32'hFFFF_FF00;
    run_phase(PERIOD_RST, TIMEOUT_RST, 1'b1, 150);

    await_all_status();
    if (mismatches == 0) begin
      $display("tb_adc_sample_acquisition_supervisor_unit OK");
    end else begin
      $display("tb_adc_sample_acquisition_supervisor_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/adcsup_pkg.sv
sv/adcsup_cfg.sv
sv/adcsup_core.sv
sv/adc_sample_acquisition_supervisor_unit.sv
verif/adcsup_result_checker.sv
verif/tb_adc_sample_acquisition_supervisor_unit.sv
